FILE: sv/ncs_pkg.sv
// ----------------------------------------------------------------------------
// ncs_pkg: shared definitions for the nearest center search
// Field widths, register defaults, action codes and score limits.
// ----------------------------------------------------------------------------
`default_nettype none

package ncs_pkg;

	localparam int CFG_BITS        = 9;
	localparam int SLOT_BITS       = 8;
	localparam int INDEX_BITS      = 8;
	localparam int SCORE_BITS      = 31;
	localparam int DEF_MAX_CENTERS = 256;
	localparam int DEF_COORD_BITS  = 16;

	localparam logic [CFG_BITS-1:0] ACTIVE_RESET = 9'd1;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic signed [31:0] SCORE_MAX = 32'sd1073741823;
	localparam logic signed [31:0] SCORE_MIN = -32'sd1073741824;

endpackage

`default_nettype wire

FILE: sv/ncs_ram.sv
// ----------------------------------------------------------------------------
// ncs_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ncs_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/ncs_dot.sv
// ----------------------------------------------------------------------------
// ncs_dot: pipelined three-term dot product
// Stage one forms the three products, stage two sums them at full precision.
// ----------------------------------------------------------------------------
`default_nettype none

module ncs_dot #(
	parameter int COORD_BITS = ncs_pkg::DEF_COORD_BITS,
	parameter int IDX_W      = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic [IDX_W-1:0]               in_idx,
	input  wire logic signed [COORD_BITS-1:0]   px,
	input  wire logic signed [COORD_BITS-1:0]   py,
	input  wire logic signed [COORD_BITS-1:0]   pz,
	input  wire logic signed [COORD_BITS-1:0]   cx,
	input  wire logic signed [COORD_BITS-1:0]   cy,
	input  wire logic signed [COORD_BITS-1:0]   cz,
	output logic                                sum_valid,
	output logic [IDX_W-1:0]                    sum_idx,
	output logic signed [2*COORD_BITS+1:0]      sum,
	output logic                                busy
);

	localparam int PROD_W = 2 * COORD_BITS;
	localparam int SUM_W  = 2 * COORD_BITS + 2;

	logic                     valid_s1;
	logic                     valid_s2;
	logic [IDX_W-1:0]         idx_s1;
	logic [IDX_W-1:0]         idx_s2;
	logic signed [PROD_W-1:0] px_s1;
	logic signed [PROD_W-1:0] py_s1;
	logic signed [PROD_W-1:0] pz_s1;
	logic signed [SUM_W-1:0]  sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= in_idx;
		px_s1  <= px * cx;
		py_s1  <= py * cy;
		pz_s1  <= pz * cz;
		idx_s2 <= idx_s1;
		sum_s2 <= SUM_W'(px_s1) + SUM_W'(py_s1) + SUM_W'(pz_s1);
	end

	assign sum_valid = valid_s2;
	assign sum_idx   = idx_s2;
	assign sum       = sum_s2;
	assign busy      = valid_s1 | valid_s2;

endmodule

`default_nettype wire

FILE: sv/nearest_center_search.sv
// ----------------------------------------------------------------------------
// nearest_center_search: nearest unit-vector center by largest dot product
// Holds a table of centers and scans it for each query point.
// ----------------------------------------------------------------------------
// A load word writes one center into the table. A query word scans entries
// 0 to min(active_centers, MAX_CENTERS)-1 one per cycle through the single
// read port of the center memory and a shared dot product pipeline. After a
// query is accepted the input stays closed until its scan has ended and the
// result is handed to the output. The result is held in an output
// register, so a new word may be accepted while it waits; a later query that
// ends its scan before that result is taken keeps the input closed until it
// is. Ties go to the lowest index. The table is not cleared at reset; every
// searched entry must be loaded before a query.
`default_nettype none

module nearest_center_search #(
	parameter int MAX_CENTERS = ncs_pkg::DEF_MAX_CENTERS,
	parameter int COORD_BITS  = ncs_pkg::DEF_COORD_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [ncs_pkg::CFG_BITS-1:0]          cfg_wdata,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  action,
	input  wire logic [ncs_pkg::SLOT_BITS-1:0]         center_slot,
	input  wire logic signed [COORD_BITS-1:0]          coord_x,
	input  wire logic signed [COORD_BITS-1:0]          coord_y,
	input  wire logic signed [COORD_BITS-1:0]          coord_z,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [ncs_pkg::INDEX_BITS-1:0]             nearest_index,
	output logic signed [ncs_pkg::SCORE_BITS-1:0]      best_score
);

	localparam int IDX_W = $clog2(MAX_CENTERS);
	localparam int CNT_W = $clog2(MAX_CENTERS + 1);
	localparam int CMP_W = (CNT_W > ncs_pkg::CFG_BITS) ? CNT_W : ncs_pkg::CFG_BITS;
	localparam int SLW   = (CNT_W > ncs_pkg::SLOT_BITS) ? CNT_W : ncs_pkg::SLOT_BITS;
	localparam int IXE_W = (IDX_W > ncs_pkg::INDEX_BITS) ? IDX_W : ncs_pkg::INDEX_BITS;
	localparam int SUM_W = 2 * COORD_BITS + 2;
	localparam int EXT_W = (SUM_W > 32) ? SUM_W : 32;
	localparam int ROW_W = 3 * COORD_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                       state_q;
	logic [ncs_pkg::CFG_BITS-1:0]     active_centers_q;
	logic [CNT_W-1:0]                 count_q;
	logic [CNT_W-1:0]                 issue_q;
	logic                             rdv_q;
	logic [IDX_W-1:0]                 rdidx_q;
	logic signed [COORD_BITS-1:0]     px_q;
	logic signed [COORD_BITS-1:0]     py_q;
	logic signed [COORD_BITS-1:0]     pz_q;
	logic                             have_q;
	logic signed [SUM_W-1:0]          best_q;
	logic [IDX_W-1:0]                 best_idx_q;
	logic                             out_valid_q;
	logic [ncs_pkg::INDEX_BITS-1:0]   nearest_index_q;
	logic signed [ncs_pkg::SCORE_BITS-1:0] best_score_q;

	logic                             in_acc;
	logic                             wr_en;
	logic [SLW-1:0]                   slot_ext;
	logic [CMP_W-1:0]                 act_ext;
	logic [CNT_W-1:0]                 count_sat;
	logic                             issue;
	logic [ROW_W-1:0]                 rd_row;
	logic                             sum_valid;
	logic [IDX_W-1:0]                 sum_idx;
	logic signed [SUM_W-1:0]          sum;
	logic                             dot_busy;
	logic                             scan_end;
	logic                             out_load;
	logic signed [EXT_W-1:0]          best_ext;
	logic signed [ncs_pkg::SCORE_BITS-1:0] score_sat;
	logic [IXE_W-1:0]                 idx_ext;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid & in_ready;
	assign slot_ext = SLW'(center_slot);
	assign wr_en    = in_acc && (action == ncs_pkg::ACT_LOAD) &&
	                  (slot_ext < SLW'(MAX_CENTERS));

	assign act_ext   = CMP_W'(active_centers_q);
	assign count_sat = (act_ext > CMP_W'(MAX_CENTERS)) ? CNT_W'(MAX_CENTERS)
	                                                   : CNT_W'(act_ext);

	assign issue = (state_q == ST_SCAN) && (issue_q < count_q);

	ncs_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_CENTERS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(slot_ext[IDX_W-1:0]),
		.wdata({coord_z, coord_y, coord_x}),
		.re   (issue),
		.raddr(issue_q[IDX_W-1:0]),
		.rdata(rd_row)
	);

	ncs_dot #(
		.COORD_BITS(COORD_BITS),
		.IDX_W     (IDX_W)
	) u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rdv_q),
		.in_idx   (rdidx_q),
		.px       (px_q),
		.py       (py_q),
		.pz       (pz_q),
		.cx       (rd_row[COORD_BITS-1:0]),
		.cy       (rd_row[2*COORD_BITS-1:COORD_BITS]),
		.cz       (rd_row[3*COORD_BITS-1:2*COORD_BITS]),
		.sum_valid(sum_valid),
		.sum_idx  (sum_idx),
		.sum      (sum),
		.busy     (dot_busy)
	);

	assign scan_end = (state_q == ST_SCAN) && (issue_q == count_q) && !rdv_q && !dot_busy;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign best_ext  = EXT_W'(best_q);
	assign score_sat = (best_ext > EXT_W'(ncs_pkg::SCORE_MAX)) ?
	                       ncs_pkg::SCORE_BITS'(ncs_pkg::SCORE_MAX) :
	                   (best_ext < EXT_W'(ncs_pkg::SCORE_MIN)) ?
	                       ncs_pkg::SCORE_BITS'(ncs_pkg::SCORE_MIN) :
	                       ncs_pkg::SCORE_BITS'(best_ext);
	assign idx_ext   = IXE_W'(best_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			active_centers_q <= ncs_pkg::ACTIVE_RESET;
			issue_q          <= '0;
			count_q          <= '0;
			rdv_q            <= 1'b0;
			have_q           <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_centers_q <= cfg_wdata;
			end
			rdv_q <= issue;
			if (issue) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			if (sum_valid && (!have_q || sum > best_q)) begin
				have_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (action == ncs_pkg::ACT_QUERY)) begin
						state_q <= ST_SCAN;
						count_q <= count_sat;
						issue_q <= '0;
						have_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rdidx_q <= issue_q[IDX_W-1:0];
		if (in_acc && (action == ncs_pkg::ACT_QUERY)) begin
			px_q       <= coord_x;
			py_q       <= coord_y;
			pz_q       <= coord_z;
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (sum_valid && (!have_q || sum > best_q)) begin
			best_q     <= sum;
			best_idx_q <= sum_idx;
		end
		if (out_load) begin
			nearest_index_q <= idx_ext[ncs_pkg::INDEX_BITS-1:0];
			best_score_q    <= score_sat;
		end
	end

	assign out_valid     = out_valid_q;
	assign nearest_index = nearest_index_q;
	assign best_score    = best_score_q;

	// The table is never written while a scan is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_IDLE))
		else $error("center write during a scan");

	// The read pointer never runs past the number of searched centers.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (issue_q <= count_q))
		else $error("scan pointer beyond active count");

	// Reads in flight only belong to a scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rdv_q || dot_busy) |-> (state_q == ST_SCAN))
		else $error("datapath busy outside a scan");

	// A held winner always lies inside the searched range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(have_q && (state_q != ST_IDLE)) |-> (CNT_W'(best_idx_q) < count_q))
		else $error("winning index outside searched range");

	// A new result word appears only when a finished scan is handed over.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result word without a finished scan");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for nearest_center_search
// Loads the center table through the input channel, runs queries under
// several active_centers settings and compares every winning index and
// score against a behavioural copy of the table kept in a scoreboard.
// Both channels idle and stall at random, with long receiver hold-offs.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	localparam int CW         = ncs_pkg::DEF_COORD_BITS;
	localparam int TABLE_SIZE = ncs_pkg::DEF_MAX_CENTERS;
	localparam int LIMIT      = 2_000_000;
	localparam int SETTLE     = 8;
	localparam int HOLD_OFF   = 1500;

	typedef logic signed [CW-1:0] coord_t;

	localparam coord_t UNIT_POS  = coord_t'(16384);
	localparam coord_t UNIT_NEG  = coord_t'(-16384);
	localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct {
		logic [ncs_pkg::INDEX_BITS-1:0]        winner;
		logic signed [ncs_pkg::SCORE_BITS-1:0] score;
	} winner_t;

	class nearest_tracker;
		coord_t                         cx[TABLE_SIZE];
		coord_t                         cy[TABLE_SIZE];
		coord_t                         cz[TABLE_SIZE];
		logic [ncs_pkg::CFG_BITS-1:0]   active;
		winner_t                        pending_winners[$];
		int                             errors;
		int                             results_seen;

		function new();
			foreach (cx[i]) begin
				cx[i] = '0;
				cy[i] = '0;
				cz[i] = '0;
			end
			active       = ncs_pkg::ACTIVE_RESET;
			errors       = 0;
			results_seen = 0;
		endfunction

		function void set_active(logic [ncs_pkg::CFG_BITS-1:0] value);
			active = value;
		endfunction

		function int pending();
			return pending_winners.size();
		endfunction

		function winner_t nearest_to(coord_t x, coord_t y, coord_t z);
			winner_t w;
			longint  best;
			longint  dot;
			int      count;
			int      best_at;
			count   = (int'(active) > TABLE_SIZE) ? TABLE_SIZE : int'(active);
			best    = 0;
			best_at = 0;
			for (int p = 0; p < count; p++) begin
				dot = longint'(x) * longint'(cx[p]) + longint'(y) * longint'(cy[p])
					+ longint'(z) * longint'(cz[p]);
				if (p == 0 || dot > best) begin
					best    = dot;
					best_at = p;
				end
			end
			if (best > longint'(ncs_pkg::SCORE_MAX))
				best = longint'(ncs_pkg::SCORE_MAX);
			if (best < longint'(ncs_pkg::SCORE_MIN))
				best = longint'(ncs_pkg::SCORE_MIN);
			w.winner = best_at[ncs_pkg::INDEX_BITS-1:0];
			w.score  = best[ncs_pkg::SCORE_BITS-1:0];
			return w;
		endfunction

		function void note_word(logic act, logic [ncs_pkg::SLOT_BITS-1:0] slot, coord_t x,
				coord_t y, coord_t z);
			if (act == ncs_pkg::ACT_LOAD) begin
				if (int'(slot) < TABLE_SIZE) begin
					cx[slot] = x;
					cy[slot] = y;
					cz[slot] = z;
				end
			end else begin
				pending_winners = {pending_winners, nearest_to(x, y, z)};
			end
		endfunction

		function void check_result(logic [ncs_pkg::INDEX_BITS-1:0] winner,
				logic signed [ncs_pkg::SCORE_BITS-1:0] score);
			winner_t w;
			results_seen++;
			if (pending_winners.size() == 0) begin
				$error("unexpected result: nearest_index %0d best_score %0d", winner, score);
				errors++;
				return;
			end
			w = pending_winners.pop_front();
			if (winner !== w.winner) begin
				$error("nearest_index: expected %0d, actual %0d", w.winner, winner);
				errors++;
			end
			if (score !== w.score) begin
				$error("best_score: expected %0d, actual %0d", w.score, score);
				errors++;
			end
		endfunction
	endclass

	logic                                  clk = 1'b0;
	logic                                  arst_n;
	logic                                  cfg_we;
	logic [ncs_pkg::CFG_BITS-1:0]          cfg_wdata;
	logic                                  in_valid;
	logic                                  in_ready;
	logic                                  action;
	logic [ncs_pkg::SLOT_BITS-1:0]         center_slot;
	coord_t                                coord_x;
	coord_t                                coord_y;
	coord_t                                coord_z;
	logic                                  out_valid;
	logic                                  out_ready;
	logic [ncs_pkg::INDEX_BITS-1:0]        nearest_index;
	logic signed [ncs_pkg::SCORE_BITS-1:0] best_score;

	nearest_tracker sb;
	int             cycles = 0;

	nearest_center_search #(
		.MAX_CENTERS(TABLE_SIZE),
		.COORD_BITS (CW)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.center_slot  (center_slot),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.nearest_index(nearest_index),
		.best_score   (best_score)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_word(action, center_slot, coord_x, coord_y, coord_z);
			if (out_valid && out_ready)
				sb.check_result(nearest_index, best_score);
		end
	end

	function automatic coord_t pick_coord();
		int v;
		case ($urandom_range(0, 7))
			0: v = $urandom();
			1: begin
				case ($urandom_range(0, 4))
					0: v = 0;
					1: v = int'(UNIT_POS);
					2: v = int'(UNIT_NEG);
					3: v = int'(COORD_MAX);
					default: v = int'(COORD_MIN);
				endcase
			end
			default: v = int'($urandom_range(0, 32768)) - 16384;
		endcase
		return coord_t'(v);
	endfunction

	task automatic send_word(logic act, logic [ncs_pkg::SLOT_BITS-1:0] slot, coord_t x,
			coord_t y, coord_t z);
		in_valid    <= 1'b1;
		action      <= act;
		center_slot <= slot;
		coord_x     <= x;
		coord_y     <= y;
		coord_z     <= z;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_active(logic [ncs_pkg::CFG_BITS-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_active(value);
	endtask

	// With fill set, slots 0 to n-1 are loaded in order; otherwise loads and queries are mixed.
	task automatic send_random_words(int n, bit fill);
		int                            left;
		int                            burst;
		int                            gap;
		int                            sent;
		logic                          act;
		logic [ncs_pkg::SLOT_BITS-1:0] slot;
		left = n;
		sent = 0;
		while (left > 0) begin
			burst = $urandom_range(1, 20);
			if (burst > left)
				burst = left;
			repeat (burst) begin
				if (fill) begin
					act  = ncs_pkg::ACT_LOAD;
					slot = sent[ncs_pkg::SLOT_BITS-1:0];
				end else begin
					act  = ($urandom_range(0, 1) == 0) ? ncs_pkg::ACT_LOAD
					                                   : ncs_pkg::ACT_QUERY;
					slot = ncs_pkg::SLOT_BITS'($urandom_range(0, 255));
				end
				send_word(act, slot, pick_coord(), pick_coord(), pick_coord());
				sent++;
			end
			left -= burst;
			if (left > 0) begin
				gap = $urandom_range(0, 6);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	function automatic logic [ncs_pkg::CFG_BITS-1:0] phase_setting(int ph);
		case (ph)
			0: return 9'd256;
			1: return 9'd1;
			2: return 9'd3;
			4: return 9'd511;
			7: return 9'd2;
			8: return ncs_pkg::CFG_BITS'($urandom_range(17, 300));
			default: return ncs_pkg::CFG_BITS'($urandom_range(2, 16));
		endcase
	endfunction

	initial begin
		int  stretch;
		logic [15:0] pat;
		bit  held_first;
		bit  held_second;
		out_ready   = 1'b0;
		held_first  = 1'b0;
		held_second = 1'b0;
		@(posedge clk);
		forever begin
			// The long hold-offs let the block fill up and stall its input.
			if (!held_first && sb.results_seen >= 60) begin
				held_first = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else if (!held_second && sb.results_seen >= 250) begin
				held_second = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end
			stretch = $urandom_range(4, 48);
			case ($urandom_range(0, 3))
				0: pat = '1;
				1: pat = 16'($urandom());
				2: pat = 16'($urandom() & $urandom() & $urandom());
				default: pat = 16'($urandom() | $urandom());
			endcase
			if (pat == '0)
				pat = 16'h0001;
			repeat (stretch) begin
				out_ready <= pat[0];
				pat = {pat[0], pat[15:1]};
				@(posedge clk);
			end
		end
	end

	initial begin
		sb          = new();
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		action      = ncs_pkg::ACT_LOAD;
		center_slot = '0;
		coord_x     = '0;
		coord_y     = '0;
		coord_z     = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The reset setting searches entry 0 alone.
		send_word(ncs_pkg::ACT_LOAD, 8'd0, UNIT_POS, '0, '0);
		send_word(ncs_pkg::ACT_QUERY, 8'hFF, UNIT_POS, '0, '0);
		send_word(ncs_pkg::ACT_LOAD, 8'd1, '0, UNIT_POS, '0);
		send_word(ncs_pkg::ACT_LOAD, 8'd2, UNIT_NEG, '0, '0);
		send_word(ncs_pkg::ACT_LOAD, 8'd3, UNIT_POS, '0, '0);
		drain();
		write_active(9'd4);
		send_word(ncs_pkg::ACT_QUERY, 8'd0, '0, UNIT_POS, '0);
		send_word(ncs_pkg::ACT_QUERY, 8'd0, UNIT_POS, '0, '0);
		send_word(ncs_pkg::ACT_QUERY, 8'd0, UNIT_NEG, '0, '0);
		send_word(ncs_pkg::ACT_QUERY, 8'd0, '0, '0, '0);
		send_word(ncs_pkg::ACT_QUERY, 8'd0, '0, '0, UNIT_POS);
		send_word(ncs_pkg::ACT_QUERY, 8'd0, UNIT_NEG, UNIT_NEG, UNIT_NEG);
		send_word(ncs_pkg::ACT_LOAD, 8'd0, COORD_MIN, COORD_MIN, COORD_MIN);
		send_word(ncs_pkg::ACT_QUERY, 8'd0, COORD_MIN, COORD_MIN, COORD_MIN);
		drain();
		write_active(9'd1);
		send_word(ncs_pkg::ACT_QUERY, 8'd0, COORD_MAX, COORD_MAX, COORD_MAX);
		drain();
		write_active(9'd0);
		send_word(ncs_pkg::ACT_QUERY, 8'd0, UNIT_POS, UNIT_POS, UNIT_POS);
		drain();

		send_random_words(TABLE_SIZE, 1'b1);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			write_active(phase_setting(ph));
			send_random_words(70, 1'b0);
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: nearest_center_search.f
sv/ncs_pkg.sv
sv/ncs_ram.sv
sv/ncs_dot.sv
sv/nearest_center_search.sv
tb/tb_top.sv
